/* src/tgq_pkg.sv */
// shared types, constants and helpers for the text glyph quad generator
package tgq_pkg;

    localparam int GLYPH_COUNT_DEF = 128;
    localparam int ATLAS_SIZE_DEF  = 512;

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_PAD_W  = 6;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int CODE_W    = 7;
    localparam int CODE_EXT_W = 9;
    localparam int UPP_W     = 24;
    localparam int PX_W      = 8;
    localparam int POS_W     = 32;
    localparam int EXT_W     = 36;
    localparam int TEX_W     = 17;
    localparam int TEXEL_W   = 10;
    localparam int TEXEL_MAX = 766;
    localparam int RECIP_SH  = 12;
    localparam int FRAC_W    = 16;

    localparam int QUAD_VERTS = 6;
    localparam int VCNT_W     = 3;

    localparam logic [TEX_W-1:0] TEX_MAX = '1;

    localparam logic [UPP_W-1:0] UPP_RESET    = 24'd65536;
    localparam logic [PX_W-1:0]  LINE_H_RESET = 8'd16;
    localparam logic [PX_W-1:0]  BASE_H_RESET = 8'd12;
    localparam logic [POS_W-1:0] LH_UPP_RESET   = 32'd1048576;
    localparam logic [POS_W-1:0] BASE_UPP_RESET = 32'd786432;
    localparam logic signed [POS_W-1:0] START_Y_RESET = -32'sd786432;

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_RENDER = 1'b1
    } kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LEFT_EDGE   = 3'd0,
        CFG_TOP_EDGE    = 3'd1,
        CFG_BOX_WIDTH   = 3'd2,
        CFG_UPP         = 3'd3,
        CFG_LINE_HEIGHT = 3'd4,
        CFG_BASE_HEIGHT = 3'd5
    } cfg_idx_t;

    // one glyph store entry, 58 bits
    typedef struct packed {
        logic [PX_W-1:0]        adv;
        logic [8:0]             atlas_t;
        logic [8:0]             atlas_s;
        logic [PX_W-1:0]        glyph_h;
        logic [PX_W-1:0]        glyph_w;
        logic signed [PX_W-1:0] off_y;
        logic signed [PX_W-1:0] off_x;
    } glyph_t;

    // clamp a wide exact position to the signed 32 bit range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [EXT_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (!v[EXT_W-1] && (|v[EXT_W-2:POS_W-1])) begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end else if (v[EXT_W-1] && !(&v[EXT_W-2:POS_W-1])) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // vertex order: tl, bl, br, br, tr, tl -> right side on 2..4, bottom on 1..3
    function automatic logic corner_right(input logic [VCNT_W-1:0] c);
        return (c >= VCNT_W'(2)) && (c <= VCNT_W'(4));
    endfunction

    function automatic logic corner_bottom(input logic [VCNT_W-1:0] c);
        return (c >= VCNT_W'(1)) && (c <= VCNT_W'(3));
    endfunction

endpackage

/* src/text_glyph_quad_generator_top.sv */
// text glyph quad generator: glyph store, pen tracking and vertex emission
// Load words (tuser[0]=0) write one glyph's metrics into the glyph store and
// produce nothing. Render words (tuser[0]=1) read the store and emit six vertex words,
// two triangles, the sixth with tlast; the output register takes the next quad as soon
// as the sixth vertex leaves. A render passes the store read, metric, pen, corner and
// output registers in that order, and each of them can stall on the one after it. The pen
// stage commits the pen before the next render reads it, so a render waits in the metric
// stage until the render ahead of it has left the pen stage. The glyph store is a
// GLYPH_COUNT-entry memory with one write and one registered read port; per-entry valid
// flops cleared at reset make unwritten entries read as zero, so no clearing pass is needed.
// Texture coordinates use a constant reciprocal multiply with one correction step.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while the block is idle.
module text_glyph_quad_generator_top #(
    parameter int GLYPH_COUNT = tgq_pkg::GLYPH_COUNT_DEF,
    parameter int ATLAS_SIZE  = tgq_pkg::ATLAS_SIZE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // char_code, glyph_offset_x, glyph_offset_y, glyph_width, glyph_height,
    // atlas_s, atlas_t, glyph_advance, zero pad
    input  logic [tgq_pkg::IN_DATA_W-1:0]      s_tdata,
    // kind, start_of_text
    input  logic [tgq_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // vertex_x, vertex_y, tex_s, tex_t, zero pad
    output logic [tgq_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [tgq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tgq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int IDX_W    = $clog2(GLYPH_COUNT);
    localparam int TEXEL_W  = tgq_pkg::TEXEL_W;
    localparam int EXT_W    = tgq_pkg::EXT_W;
    localparam int POS_W    = tgq_pkg::POS_W;
    localparam int TEX_W    = tgq_pkg::TEX_W;
    localparam int RECIP    = (1 << (tgq_pkg::FRAC_W + tgq_pkg::RECIP_SH)) / ATLAS_SIZE;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int Q_MAX    = (tgq_pkg::TEXEL_MAX << tgq_pkg::FRAC_W) / ATLAS_SIZE;
    localparam int Q_W      = $clog2(Q_MAX + 1);
    localparam int ATLAS_W  = $clog2(ATLAS_SIZE + 1);
    localparam int PROD_W   = TEXEL_W + RECIP_W;
    localparam int SCALED_W = TEXEL_W + tgq_pkg::FRAC_W;
    localparam int QA_W     = Q_W + ATLAS_W;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [ATLAS_W-1:0] ATLAS_C = ATLAS_W'(ATLAS_SIZE);

    // ---------------------------------------------------------------- input word
    logic [tgq_pkg::CODE_W-1:0]     in_code;
    logic [tgq_pkg::CODE_EXT_W-1:0] code_ext;
    logic [IDX_W-1:0]               in_idx;
    logic                           in_range;
    tgq_pkg::glyph_t                in_glyph;
    tgq_pkg::kind_t                 in_kind;
    logic                           in_start;
    logic                           accept;
    logic                           accept_load;
    logic                           accept_render;

    assign in_code           = s_tdata[6:0];
    assign in_glyph.off_x    = s_tdata[14:7];
    assign in_glyph.off_y    = s_tdata[22:15];
    assign in_glyph.glyph_w  = s_tdata[30:23];
    assign in_glyph.glyph_h  = s_tdata[38:31];
    assign in_glyph.atlas_s  = s_tdata[47:39];
    assign in_glyph.atlas_t  = s_tdata[56:48];
    assign in_glyph.adv      = s_tdata[64:57];
    assign in_kind           = tgq_pkg::kind_t'(s_tuser[0]);
    assign in_start          = s_tuser[1];

    assign code_ext      = {2'b00, in_code};
    assign in_idx        = code_ext[IDX_W-1:0];
    assign in_range      = code_ext < tgq_pkg::CODE_EXT_W'(GLYPH_COUNT);
    assign accept        = s_tvalid && s_tready;
    assign accept_load   = accept && (in_kind == tgq_pkg::KIND_LOAD);
    assign accept_render = accept && (in_kind == tgq_pkg::KIND_RENDER);

    // ---------------------------------------------------------------- config
    logic signed [POS_W-1:0]      left_reg;
    logic signed [POS_W-1:0]      top_reg;
    logic signed [POS_W-1:0]      box_reg;
    logic [tgq_pkg::UPP_W-1:0]    upp_reg;
    logic [tgq_pkg::PX_W-1:0]     line_h_reg;
    logic [tgq_pkg::PX_W-1:0]     base_h_reg;
    logic [POS_W-1:0]             lh_upp_reg;
    logic [POS_W-1:0]             base_upp_reg;
    logic signed [POS_W-1:0]      start_y_reg;

    // ---------------------------------------------------------------- pipeline state
    logic                         v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                         fire1, fire2, fire3, fire4, out_done;
    logic signed [POS_W-1:0]      pen_x_reg, pen_y_reg;
    logic signed [POS_W-1:0]      pen_x_next, pen_y_next;
    logic [GLYPH_COUNT-1:0]       valid_reg;
    logic [tgq_pkg::VCNT_W-1:0]   vert_cnt_reg;

    tgq_pkg::glyph_t              glyph_mem [GLYPH_COUNT];

    // stage 1: glyph read data
    logic                         start1_reg;
    tgq_pkg::glyph_t              rd_glyph_reg;
    logic                         rd_ok_reg;

    // stage 2: scaled metrics
    logic                         start2_reg;
    logic signed [32:0]           ox_upp2_reg;
    logic signed [33:0]           boy_upp2_reg;
    logic [POS_W-1:0]             w_upp2_reg, h_upp2_reg, adv_upp2_reg;
    logic [3:0][TEXEL_W-1:0]      texel2_reg;

    // stage 3: pen snapshot and sums
    logic signed [POS_W-1:0]      px3_reg, py3_reg;
    logic signed [EXT_W-1:0]      sumx3_reg, ydec3_reg;
    logic signed [32:0]           ox_upp3_reg;
    logic signed [33:0]           boy_upp3_reg;
    logic [POS_W-1:0]             w_upp3_reg, h_upp3_reg;
    logic [3:0][TEXEL_W-1:0]      texel3_reg;
    logic [3:0][Q_W-1:0]          q0_3_reg;

    // stage 4: quad corners before the second add
    logic signed [EXT_W-1:0]      xmin4_reg, ymax4_reg;
    logic [POS_W-1:0]             w_upp4_reg, h_upp4_reg;
    logic [3:0][TEXEL_W-1:0]      texel4_reg;
    logic [3:0][Q_W-1:0]          q0_4_reg;
    logic [3:0][SCALED_W-1:0]     q0a4_reg;

    // stage 5: quad held for vertex emission
    logic signed [POS_W-1:0]      qx_lo_reg, qx_hi_reg, qy_lo_reg, qy_hi_reg;
    logic [TEX_W-1:0]             qs_lo_reg, qs_hi_reg, qt_lo_reg, qt_hi_reg;

    // ---------------------------------------------------------------- handshake
    assign out_done = m_tvalid && m_tready && m_tlast;
    assign fire4    = v4_reg && (!v5_reg || out_done);
    assign fire3    = v3_reg && (!v4_reg || fire4);
    // pen is read here only once the previous render has committed it
    assign fire2    = v2_reg && !v3_reg;
    assign fire1    = v1_reg && (!v2_reg || fire2);
    assign s_tready = !v1_reg || fire1;

    // ---------------------------------------------------------------- stage 1 logic
    tgq_pkg::glyph_t          g1;
    logic signed [9:0]        boy1;
    logic signed [32:0]       ox_upp1;
    logic signed [33:0]       boy_upp1;
    logic [POS_W-1:0]         w_upp1, h_upp1, adv_upp1;
    logic [3:0][TEXEL_W-1:0]  texel1;

    always_comb begin
        g1       = rd_ok_reg ? rd_glyph_reg : '0;
        boy1     = $signed({2'b00, base_h_reg}) - $signed({{2{g1.off_y[7]}}, g1.off_y});
        ox_upp1  = $signed({{25{g1.off_x[7]}}, g1.off_x}) * $signed({9'b0, upp_reg});
        boy_upp1 = $signed({{24{boy1[9]}}, boy1}) * $signed({10'b0, upp_reg});
        w_upp1   = {24'b0, g1.glyph_w} * {8'b0, upp_reg};
        h_upp1   = {24'b0, g1.glyph_h} * {8'b0, upp_reg};
        adv_upp1 = {24'b0, g1.adv} * {8'b0, upp_reg};
        texel1[0] = {1'b0, g1.atlas_s};
        texel1[1] = {1'b0, g1.atlas_s} + {2'b00, g1.glyph_w};
        texel1[2] = {1'b0, g1.atlas_t};
        texel1[3] = {1'b0, g1.atlas_t} + {2'b00, g1.glyph_h};
    end

    // ---------------------------------------------------------------- stage 2 logic
    logic signed [POS_W-1:0]  px2, py2;
    logic signed [EXT_W-1:0]  sumx2, ydec2;
    logic [3:0][Q_W-1:0]      q0_2;
    logic [PROD_W-1:0]        recip_prod;
    logic [PROD_W-1:0]        recip_shift;

    always_comb begin
        recip_prod  = '0;
        recip_shift = '0;
        px2   = start2_reg ? left_reg : pen_x_reg;
        py2   = start2_reg ? start_y_reg : pen_y_reg;
        sumx2 = EXT_W'(px2) + $signed(EXT_W'(adv_upp2_reg));
        ydec2 = EXT_W'(py2) - $signed(EXT_W'(lh_upp_reg));
        for (int i = 0; i < 4; i++) begin
            recip_prod  = {{RECIP_W{1'b0}}, texel2_reg[i]} * {{TEXEL_W{1'b0}}, RECIP_C};
            recip_shift = recip_prod >> tgq_pkg::RECIP_SH;
            q0_2[i]     = Q_W'(recip_shift);
        end
    end

    // ---------------------------------------------------------------- stage 3 logic
    logic signed [POS_W-1:0]   px_sat3;
    logic signed [EXT_W-1:0]   wrap_sum3;
    logic                      wrap3;
    logic signed [EXT_W-1:0]   xmin3, ymax3;
    logic [3:0][SCALED_W-1:0]  q0a3;
    logic [QA_W-1:0]           qa_prod;

    always_comb begin
        qa_prod    = '0;
        px_sat3    = tgq_pkg::sat_pos(sumx3_reg);
        wrap_sum3  = EXT_W'(px_sat3) + $signed(EXT_W'(lh_upp_reg));
        wrap3      = wrap_sum3 > EXT_W'(box_reg);
        pen_x_next = wrap3 ? left_reg : px_sat3;
        pen_y_next = wrap3 ? tgq_pkg::sat_pos(ydec3_reg) : py3_reg;
        xmin3      = EXT_W'(px3_reg) + EXT_W'(ox_upp3_reg);
        ymax3      = EXT_W'(py3_reg) + EXT_W'(boy_upp3_reg);
        for (int i = 0; i < 4; i++) begin
            qa_prod = {{ATLAS_W{1'b0}}, q0_3_reg[i]} * {{Q_W{1'b0}}, ATLAS_C};
            q0a3[i] = SCALED_W'(qa_prod);
        end
    end

    // ---------------------------------------------------------------- stage 4 logic
    logic signed [POS_W-1:0]  x_lo4, x_hi4, y_lo4, y_hi4;
    logic [3:0][TEX_W-1:0]    tex4;
    logic [SCALED_W-1:0]      rem4;
    logic [Q_W:0]             q4;

    always_comb begin
        rem4  = '0;
        q4    = '0;
        x_lo4 = tgq_pkg::sat_pos(xmin4_reg);
        x_hi4 = tgq_pkg::sat_pos(xmin4_reg + $signed(EXT_W'(w_upp4_reg)));
        y_hi4 = tgq_pkg::sat_pos(ymax4_reg);
        y_lo4 = tgq_pkg::sat_pos(ymax4_reg - $signed(EXT_W'(h_upp4_reg)));
        for (int i = 0; i < 4; i++) begin
            // quotient estimate is exact or one low
            rem4 = {texel4_reg[i], {tgq_pkg::FRAC_W{1'b0}}} - q0a4_reg[i];
            q4   = {1'b0, q0_4_reg[i]} + (Q_W+1)'(rem4 >= SCALED_W'(ATLAS_SIZE));
            tex4[i] = (q4 > (Q_W+1)'(tgq_pkg::TEX_MAX)) ? tgq_pkg::TEX_MAX : TEX_W'(q4);
        end
    end

    // ---------------------------------------------------------------- glyph store
    always_ff @(posedge aclk) begin
        if (accept_load && in_range) begin
            glyph_mem[in_idx] <= in_glyph;
        end
        if (accept_render) begin
            rd_glyph_reg <= glyph_mem[in_idx];
        end
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg     <= '0;
            top_reg      <= '0;
            box_reg      <= '0;
            upp_reg      <= tgq_pkg::UPP_RESET;
            line_h_reg   <= tgq_pkg::LINE_H_RESET;
            base_h_reg   <= tgq_pkg::BASE_H_RESET;
            lh_upp_reg   <= tgq_pkg::LH_UPP_RESET;
            base_upp_reg <= tgq_pkg::BASE_UPP_RESET;
            start_y_reg  <= tgq_pkg::START_Y_RESET;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            pen_x_reg    <= '0;
            pen_y_reg    <= '0;
            valid_reg    <= '0;
            vert_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (tgq_pkg::cfg_idx_t'(cfg_addr))
                    tgq_pkg::CFG_LEFT_EDGE:   left_reg   <= cfg_wdata;
                    tgq_pkg::CFG_TOP_EDGE:    top_reg    <= cfg_wdata;
                    tgq_pkg::CFG_BOX_WIDTH:   box_reg    <= cfg_wdata;
                    tgq_pkg::CFG_UPP:         upp_reg    <= cfg_wdata[tgq_pkg::UPP_W-1:0];
                    tgq_pkg::CFG_LINE_HEIGHT: line_h_reg <= cfg_wdata[tgq_pkg::PX_W-1:0];
                    tgq_pkg::CFG_BASE_HEIGHT: base_h_reg <= cfg_wdata[tgq_pkg::PX_W-1:0];
                    default: ;
                endcase
            end
            // derived from config, settled long before a render reaches the pen stage
            lh_upp_reg   <= {24'b0, line_h_reg} * {8'b0, upp_reg};
            base_upp_reg <= {24'b0, base_h_reg} * {8'b0, upp_reg};
            start_y_reg  <= tgq_pkg::sat_pos(EXT_W'(top_reg) - $signed(EXT_W'(base_upp_reg)));

            if (accept_load && in_range) begin
                valid_reg[in_idx] <= 1'b1;
            end

            if (accept_render) begin
                v1_reg <= 1'b1;
            end else if (fire1) begin
                v1_reg <= 1'b0;
            end
            if (fire1) begin
                v2_reg <= 1'b1;
            end else if (fire2) begin
                v2_reg <= 1'b0;
            end
            if (fire2) begin
                v3_reg <= 1'b1;
            end else if (fire3) begin
                v3_reg <= 1'b0;
            end
            if (fire3) begin
                v4_reg    <= 1'b1;
                pen_x_reg <= pen_x_next;
                pen_y_reg <= pen_y_next;
            end else if (fire4) begin
                v4_reg <= 1'b0;
            end
            if (fire4) begin
                v5_reg <= 1'b1;
            end else if (out_done) begin
                v5_reg <= 1'b0;
            end

            if (m_tvalid && m_tready) begin
                vert_cnt_reg <= m_tlast ? '0 : vert_cnt_reg + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge aclk) begin
        if (accept_render) begin
            start1_reg <= in_start;
            rd_ok_reg  <= in_range && valid_reg[in_idx];
        end
        if (fire1) begin
            start2_reg   <= start1_reg;
            ox_upp2_reg  <= ox_upp1;
            boy_upp2_reg <= boy_upp1;
            w_upp2_reg   <= w_upp1;
            h_upp2_reg   <= h_upp1;
            adv_upp2_reg <= adv_upp1;
            texel2_reg   <= texel1;
        end
        if (fire2) begin
            px3_reg      <= px2;
            py3_reg      <= py2;
            sumx3_reg    <= sumx2;
            ydec3_reg    <= ydec2;
            ox_upp3_reg  <= ox_upp2_reg;
            boy_upp3_reg <= boy_upp2_reg;
            w_upp3_reg   <= w_upp2_reg;
            h_upp3_reg   <= h_upp2_reg;
            texel3_reg   <= texel2_reg;
            q0_3_reg     <= q0_2;
        end
        if (fire3) begin
            xmin4_reg  <= xmin3;
            ymax4_reg  <= ymax3;
            w_upp4_reg <= w_upp3_reg;
            h_upp4_reg <= h_upp3_reg;
            texel4_reg <= texel3_reg;
            q0_4_reg   <= q0_3_reg;
            q0a4_reg   <= q0a3;
        end
        if (fire4) begin
            qx_lo_reg <= x_lo4;
            qx_hi_reg <= x_hi4;
            qy_lo_reg <= y_lo4;
            qy_hi_reg <= y_hi4;
            qs_lo_reg <= tex4[0];
            qs_hi_reg <= tex4[1];
            qt_lo_reg <= tex4[2];
            qt_hi_reg <= tex4[3];
        end
    end

    // ---------------------------------------------------------------- vertex output
    logic                    use_right, use_bottom;
    logic signed [POS_W-1:0] out_x, out_y;
    logic [TEX_W-1:0]        out_s, out_t;

    always_comb begin
        use_right  = tgq_pkg::corner_right(vert_cnt_reg);
        use_bottom = tgq_pkg::corner_bottom(vert_cnt_reg);
        out_x = use_right  ? qx_hi_reg : qx_lo_reg;
        out_s = use_right  ? qs_hi_reg : qs_lo_reg;
        out_y = use_bottom ? qy_lo_reg : qy_hi_reg;
        out_t = use_bottom ? qt_hi_reg : qt_lo_reg;
    end

    assign m_tvalid = v5_reg;
    assign m_tlast  = vert_cnt_reg == tgq_pkg::VCNT_W'(tgq_pkg::QUAD_VERTS - 1);
    assign m_tdata  = {{tgq_pkg::OUT_PAD_W{1'b0}}, out_t, out_s, out_y, out_x};

`ifndef SYNTH
    a_vert_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vert_cnt_reg <= tgq_pkg::VCNT_W'(tgq_pkg::QUAD_VERTS - 1))
        else $error("vertex counter past the last corner");

    a_cnt_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (vert_cnt_reg == '0))
        else $error("vertex counter did not restart after the last vertex");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_load |=> (v1_reg == $past(v1_reg && !fire1)))
        else $error("load word entered the render pipeline");

    a_pen_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        fire3 |=> !(v3_reg && !$past(fire2)))
        else $error("pen stage held a render without a pen commit in between");
`endif

endmodule
